// ===== rtl/psc_pkg.sv =====
// Shared constants and types for the path syntax checker.
`default_nettype none

package psc_pkg;

    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int OFF_W   = 13;
    localparam int UP_W    = 12;
    localparam int CNT_W   = 13;

    localparam logic [7:0]      CH_SLASH = 8'h2F;
    localparam logic [7:0]      CH_DOT   = 8'h2E;
    localparam logic [UP_W-1:0] UP_MAX   = {UP_W{1'b1}};

    localparam logic KIND_COMP = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_DOT1,
        PH_DOT2,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] offset;
        logic             valid_res;
        logic             absolute;
        logic [UP_W-1:0]  go_up;
        logic [CNT_W-1:0] components;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/path_syntax_checker.sv =====
// Top level of the streaming path syntax checker.
//
// Input channel: one path byte per transfer on i_ch with i_is_end low; a
// transfer with i_is_end high ends the path (i_ch ignored). A transfer takes
// place at a rising edge with i_valid high and o_stall low.
// Output channel: a transfer takes place at a rising edge with o_valid high
// and i_stall low. kind 0 reports the start offset of the next component at
// each body slash; kind 1 is the end-of-path summary (valid, absolute,
// go-up count, component count, body start).
// The result of an input transfer taken at an edge is on the output ports
// right after that edge when the output register is free; else it waits in the skid entry.
// Throughput: one input transfer per cycle, sustained, as long as the
// receiver takes results. The parse step is combinational logic between
// the path state registers and the result register.
// Stall: when the receiver stalls, the result register holds and one more
// result lands in a skid entry; o_stall rises only once that entry is full.
// Reset (synchronous, i_rst_n low): parse state returns to start of path and
// both output entries are emptied. Paths longer than MAX_LEN are reported
// invalid.
`default_nettype none

module path_syntax_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [7:0]                  i_ch,
    input  wire logic                        i_is_end,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_kind,
    output logic [psc_pkg::OFF_W-1:0]        o_offset,
    output logic                             o_valid_res,
    output logic                             o_absolute,
    output logic [psc_pkg::UP_W-1:0]         o_go_up,
    output logic [psc_pkg::CNT_W-1:0]        o_components
);

    logic             accept;
    logic             res_valid;
    logic             full;
    psc_pkg::t_result res;
    psc_pkg::t_result out_res;

    // input is held off only when the skid entry is occupied
    assign o_stall = full;
    assign accept  = i_valid && !full;

    psc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ch        (i_ch),
        .i_is_end    (i_is_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    psc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    assign o_kind       = out_res.kind;
    assign o_offset     = out_res.offset;
    assign o_valid_res  = out_res.valid_res;
    assign o_absolute   = out_res.absolute;
    assign o_go_up      = out_res.go_up;
    assign o_components = out_res.components;

endmodule

`default_nettype wire

// ===== rtl/psc_core.sv =====
// Path state registers and the per-character parse step.
`default_nettype none

module psc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_ch,
    input  wire logic            i_is_end,
    output logic                 o_res_valid,
    output psc_pkg::t_result     o_res
);

    psc_pkg::t_phase                r_phase, n_phase;
    logic                           r_prev_slash, n_prev_slash;
    logic                           r_still_valid, n_still_valid;
    logic                           r_absolute, n_absolute;
    logic [psc_pkg::UP_W-1:0]       r_up, n_up;
    logic [psc_pkg::CNT_W-1:0]      r_slash_cnt, n_slash_cnt;
    logic [psc_pkg::POS_W-1:0]      r_char_pos, n_char_pos;
    logic [psc_pkg::OFF_W-1:0]      r_body_start, n_body_start;

    logic                           ok;
    logic                           body;
    logic [psc_pkg::POS_W:0]        pos_inc;
    logic [psc_pkg::OFF_W-1:0]      bstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= psc_pkg::PH_START;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_slash  <= 1'b0;
            r_still_valid <= 1'b1;
            r_absolute    <= 1'b0;
            r_up          <= '0;
            r_slash_cnt   <= '0;
            r_char_pos    <= '0;
            r_body_start  <= '0;
        end else if (i_accept) begin
            r_prev_slash  <= n_prev_slash;
            r_still_valid <= n_still_valid;
            r_absolute    <= n_absolute;
            r_up          <= n_up;
            r_slash_cnt   <= n_slash_cnt;
            r_char_pos    <= n_char_pos;
            r_body_start  <= n_body_start;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_prev_slash  = r_prev_slash;
        n_still_valid = r_still_valid;
        n_absolute    = r_absolute;
        n_up          = r_up;
        n_slash_cnt   = r_slash_cnt;
        n_char_pos    = r_char_pos;
        n_body_start  = r_body_start;
        o_res_valid   = 1'b0;
        o_res         = '0;
        body          = 1'b0;
        pos_inc       = {1'b0, r_char_pos} + 1'b1;
        ok            = r_still_valid &&
                        (r_phase == psc_pkg::PH_PREFIX || r_phase == psc_pkg::PH_BODY);
        bstart        = (r_phase == psc_pkg::PH_PREFIX) ?
                        psc_pkg::OFF_W'(r_char_pos) : r_body_start;

        if (i_is_end) begin
            // summary; all fields but kind zero when the path is bad
            o_res_valid = 1'b1;
            o_res.kind  = psc_pkg::KIND_SUM;
            if (ok) begin
                o_res.offset     = bstart;
                o_res.valid_res  = 1'b1;
                o_res.absolute   = r_absolute;
                o_res.go_up      = r_up;
                o_res.components = r_slash_cnt + 1'b1;
            end
            n_phase       = psc_pkg::PH_START;
            n_prev_slash  = 1'b0;
            n_still_valid = 1'b1;
            n_absolute    = 1'b0;
            n_up          = '0;
            n_slash_cnt   = '0;
            n_char_pos    = '0;
            n_body_start  = '0;
        end else if (r_still_valid) begin
            if (r_char_pos >= psc_pkg::POS_W'(psc_pkg::MAX_LEN)) begin
                n_still_valid = 1'b0;
            end else begin
                n_char_pos = psc_pkg::POS_W'(pos_inc);
                unique case (r_phase)
                    psc_pkg::PH_START: begin
                        if (i_ch == psc_pkg::CH_SLASH) begin
                            n_absolute   = 1'b1;
                            n_up         = '0;
                            n_prev_slash = 1'b1;
                            n_body_start = psc_pkg::OFF_W'(1);
                            n_phase      = psc_pkg::PH_BODY;
                        end else begin
                            n_up = psc_pkg::UP_W'(1);
                            if (i_ch == psc_pkg::CH_DOT) begin
                                n_phase = psc_pkg::PH_DOT1;
                            end else begin
                                n_body_start = psc_pkg::OFF_W'(r_char_pos);
                                n_phase      = psc_pkg::PH_BODY;
                                body         = 1'b1;
                            end
                        end
                    end
                    psc_pkg::PH_PREFIX: begin
                        if (i_ch == psc_pkg::CH_DOT) begin
                            n_phase = psc_pkg::PH_DOT1;
                        end else begin
                            n_body_start = psc_pkg::OFF_W'(r_char_pos);
                            n_phase      = psc_pkg::PH_BODY;
                            body         = 1'b1;
                        end
                    end
                    psc_pkg::PH_DOT1: begin
                        if (i_ch == psc_pkg::CH_DOT) begin
                            if (r_up < psc_pkg::UP_MAX) begin
                                n_up = r_up + 1'b1;
                            end
                            n_phase = psc_pkg::PH_DOT2;
                        end else if (i_ch == psc_pkg::CH_SLASH) begin
                            n_prev_slash = 1'b1;
                            n_phase      = psc_pkg::PH_PREFIX;
                        end else begin
                            n_still_valid = 1'b0;
                        end
                    end
                    psc_pkg::PH_DOT2: begin
                        if (i_ch == psc_pkg::CH_SLASH) begin
                            n_prev_slash = 1'b1;
                            n_phase      = psc_pkg::PH_PREFIX;
                        end else begin
                            n_still_valid = 1'b0;
                        end
                    end
                    default: begin
                        body = 1'b1;
                    end
                endcase

                if (body) begin
                    if (i_ch != psc_pkg::CH_SLASH) begin
                        n_prev_slash = 1'b0;
                    end else if (r_prev_slash) begin
                        n_still_valid = 1'b0;
                    end else begin
                        n_prev_slash = 1'b1;
                        n_slash_cnt  = r_slash_cnt + 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.kind   = psc_pkg::KIND_COMP;
                        o_res.offset = psc_pkg::OFF_W'(pos_inc);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/psc_outbuf.sv =====
// Result register with one skid entry behind it.
`default_nettype none

module psc_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire psc_pkg::t_result i_res,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output psc_pkg::t_result      o_res,
    output logic                  o_full
);

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    psc_pkg::t_result r_out, n_out;
    psc_pkg::t_result r_skid, n_skid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_res;
            end else begin
                n_out_valid = i_push;
                n_out       = i_res;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// ===== rtl/psc_checker.sv =====
// Port-level assertions for the path syntax checker, bound to the top level.
`default_nettype none

module psc_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_valid,
    input  wire logic                        i_stall,
    input  wire logic                        o_kind,
    input  wire logic [psc_pkg::OFF_W-1:0]   o_offset,
    input  wire logic                        o_valid_res,
    input  wire logic                        o_absolute,
    input  wire logic [psc_pkg::UP_W-1:0]    o_go_up,
    input  wire logic [psc_pkg::CNT_W-1:0]   o_components
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_offset)
                               && $stable(o_components))
        else $error("stalled result changed");

    a_comp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == psc_pkg::KIND_COMP) |->
            !o_valid_res && !o_absolute && o_go_up == '0 && o_components == '0
            && o_offset != '0)
        else $error("component event carries summary fields");

    a_bad_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == psc_pkg::KIND_SUM) && !o_valid_res |->
            !o_absolute && o_go_up == '0 && o_components == '0 && o_offset == '0)
        else $error("invalid summary has nonzero fields");

    a_abs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == psc_pkg::KIND_SUM) && o_valid_res |->
            (o_absolute && o_go_up == '0 && o_offset == psc_pkg::OFF_W'(1)) ||
            (!o_absolute && o_go_up != '0))
        else $error("summary go-up count inconsistent with absolute flag");

endmodule

bind path_syntax_checker psc_checker u_psc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_offset     (o_offset),
    .o_valid_res  (o_valid_res),
    .o_absolute   (o_absolute),
    .o_go_up      (o_go_up),
    .o_components (o_components)
);

`default_nettype wire
